// ----- design/rar1v_pkg.sv -----
// ----------------------------------------------------------------------------
// rar1v_pkg: shared types and constants
// Widths, fixed-point constants, register indexes and sequencer states for the
// rolling AR(1) innovation variance block.
// ----------------------------------------------------------------------------
package rar1v_pkg;

  localparam int MAX_WINDOW     = 63;
  localparam int SAMPLE_BITS    = 24;
  localparam int WIN_W          = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W          = $clog2(MAX_WINDOW);
  localparam int LEN_W          = 32;
  localparam int SUM_S_W        = 30;
  localparam int SUM_Q_W        = 54;
  localparam int SUM_P_W        = 55;
  localparam int VAR_W          = 48;
  localparam int ACC_W          = 96;  // working width of the shared datapath
  localparam int MB_W           = 33;  // multiplier operand, signed
  localparam int STEP_W         = 6;   // step counter of the serial units
  localparam int DEFAULT_WINDOW = 31;
  localparam int MIN_WINDOW     = 5;
  localparam int BETA_W         = 30;
  localparam int BETA_CAP       = 1063004406;  // 0.99 in Q1.30
  localparam int Q30_ONE        = 1073741824;
  localparam int REG_FACTOR     = 10000;
  localparam int BETA_STEPS     = 30;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACK_LENGTH = 1'b0,
    REG_REQ_WINDOW   = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_M_DD,
    ST_M_DL,
    ST_M_PX,
    ST_M_XX,
    ST_V_SS,
    ST_V_G,
    ST_V_H1,
    ST_V_H2,
    ST_V_H3,
    ST_V_H4,
    ST_V_NUM,
    ST_V_D1,
    ST_V_D2,
    ST_V_D3,
    ST_V_CMP,
    ST_V_DIV,
    ST_V_BB,
    ST_V_GP,
    ST_V_SAT,
    ST_V_DIV2,
    ST_LOAD
  } state_t;

endpackage

// ----- design/rar1v_dline.sv -----
// ----------------------------------------------------------------------------
// rar1v_dline: sample delay line
// Circular sample store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rar1v_dline (
  input  logic                        clk,
  input  logic                        we,
  input  logic [rar1v_pkg::PTR_W-1:0] waddr,
  input  rar1v_pkg::sample_t          wdata,
  input  logic [rar1v_pkg::PTR_W-1:0] raddr,
  output rar1v_pkg::sample_t          rdata
);

  rar1v_pkg::sample_t mem [rar1v_pkg::MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rar1v_mul.sv -----
// ----------------------------------------------------------------------------
// rar1v_mul: bit-serial multiplier
// Wide signed operand times a signed MB_W-bit operand, one bit per cycle.
// ----------------------------------------------------------------------------
module rar1v_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  rar1v_pkg::acc_t                   a,
  input  logic signed [rar1v_pkg::MB_W-1:0] b,
  output logic                              done,
  output rar1v_pkg::acc_t                   p
);

  rar1v_pkg::acc_t                 acc_r;
  rar1v_pkg::acc_t                 ash_r;
  logic [rar1v_pkg::MB_W-1:0]      bsh_r;
  logic [rar1v_pkg::STEP_W-1:0]    cnt_r;
  logic                            run_r;
  logic                            done_r;
  logic                            last_c;

  // top bit of b carries negative weight
  assign last_c = (cnt_r == rar1v_pkg::STEP_W'(rar1v_pkg::MB_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last_c) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      ash_r <= a;
      bsh_r <= b;
      cnt_r <= '0;
    end else if (run_r) begin
      if (bsh_r[0]) begin
        acc_r <= last_c ? acc_r - ash_r : acc_r + ash_r;
      end
      ash_r <= ash_r <<< 1;
      bsh_r <= bsh_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- design/rar1v_div.sv -----
// ----------------------------------------------------------------------------
// rar1v_div: restoring divider
// One quotient bit per cycle; remainder preset, dividend bits shifted in.
// ----------------------------------------------------------------------------
module rar1v_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rar1v_pkg::ACC_W-1:0]        rem0,
  input  logic [rar1v_pkg::ACC_W-1:0]        den,
  input  logic [rar1v_pkg::VAR_W-1:0]        dvd,
  input  logic [rar1v_pkg::STEP_W-1:0]       steps,
  output logic                               done,
  output logic [rar1v_pkg::VAR_W-1:0]        q
);

  logic [rar1v_pkg::ACC_W-1:0]  rem_r;
  logic [rar1v_pkg::ACC_W-1:0]  den_r;
  logic [rar1v_pkg::VAR_W-1:0]  dv_r;
  logic [rar1v_pkg::VAR_W-1:0]  q_r;
  logic [rar1v_pkg::STEP_W-1:0] cnt_r;
  logic [rar1v_pkg::STEP_W-1:0] steps_r;
  logic                         run_r;
  logic                         done_r;
  logic [rar1v_pkg::ACC_W-1:0]  r2_c;
  logic                         ge_c;
  logic                         last_c;

  assign r2_c   = {rem_r[rar1v_pkg::ACC_W-2:0], dv_r[rar1v_pkg::VAR_W-1]};
  assign ge_c   = (r2_c >= den_r);
  assign last_c = (cnt_r == steps_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last_c) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= rem0;
      den_r   <= den;
      dv_r    <= dvd;
      q_r     <= '0;
      cnt_r   <= '0;
      steps_r <= steps;
    end else if (run_r) begin
      rem_r <= ge_c ? r2_c - den_r : r2_c;
      q_r   <= {q_r[rar1v_pkg::VAR_W-2:0], ge_c};
      dv_r  <= dv_r << 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- design/rolling_ar1_innovation_variance.sv -----
// ----------------------------------------------------------------------------
// rolling_ar1_innovation_variance: sliding-window AR(1) residual variance
// Streams a track of Q12.12 samples and returns one Q24.24 variance per
// track position, from the odd window centered on it.
// ----------------------------------------------------------------------------
// Usage: program the track length and the window request (0 picks 31), then
// stream the track's samples; the settings are latched at a track's first
// sample and writes during a track apply from the next one. The window is
// forced odd, at least 5, at most the track length and 63. Samples that fill
// the first window return nothing; the beat that completes it returns W/2+1
// results, each later sample returns one, and the last sample also returns
// W/2 replicas of the final window; out_is_last flags the track's final
// result. Tracks shorter than 5 return one zero per sample. Throughput: one
// sample is taken at a time. The last W samples sit in a circular memory
// (two reads, one write per sample); all products go through one bit-serial
// multiplier of 33 steps and a bit-serial divider. Every sample passes the
// sequencing steps (accept, two reads, write, load) plus its products: one
// for a track's first sample, two for a later filling sample, four for the
// sum update once the window is full. A sample that closes a window adds up
// to twelve more products, a compare, a 30-step beta division, a saturation
// check and a 48-step scaling division; the beta division is skipped when
// beta is forced to zero or to its cap, and the scaling division when the
// result saturates. A short-track sample goes from accept straight to load.
// The load step of a sample that owes results also waits while the previous
// sample's beats are still draining. Results sit in an output register, so
// the next sample is taken while the previous sample's beats drain. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module rolling_ar1_innovation_variance (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rar1v_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rar1v_pkg::VAR_W-1:0]            out_variance,
  output logic                                   out_is_last,
  input  logic                                   cfg_we,
  input  logic [rar1v_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rar1v_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int WIN_W = rar1v_pkg::WIN_W;
  localparam int LEN_W = rar1v_pkg::LEN_W;
  localparam int ACC_W = rar1v_pkg::ACC_W;
  localparam int MB_W  = rar1v_pkg::MB_W;
  localparam int PTR_W = rar1v_pkg::PTR_W;
  localparam int VAR_W = rar1v_pkg::VAR_W;
  localparam int WSQ_W = 2 * WIN_W;
  localparam int RF_W  = $clog2(rar1v_pkg::REG_FACTOR * (rar1v_pkg::MAX_WINDOW + 3));

  rar1v_pkg::state_t state_r, state_nxt;

  // configuration and per-track control
  logic [LEN_W-1:0]   cfg_len_r;
  logic [WIN_W-1:0]   cfg_win_r;
  logic [LEN_W-1:0]   len_r;
  logic [WIN_W-1:0]   w_r;
  logic [LEN_W-1:0]   n_r;
  logic [PTR_W-1:0]   wp_r;
  logic               issued_r;

  // running sums
  logic signed [rar1v_pkg::SUM_S_W-1:0] s_r;
  logic [rar1v_pkg::SUM_Q_W-1:0]        q_r;
  logic signed [rar1v_pkg::SUM_P_W-1:0] p_r;

  // per-sample datapath
  rar1v_pkg::sample_t x_r, prev_r, d_r, l_r;
  rar1v_pkg::acc_t    s2_r, g_r, h_r, t_r, num_r, den_r, xv_r;
  logic [rar1v_pkg::BETA_W-1:0] beta_r;
  logic [rar1v_pkg::BETA_W:0]   om_r;
  logic [VAR_W-1:0]             var_r;

  // output register
  logic [VAR_W-1:0]   obuf_var_r;
  logic [WIN_W-1:0]   obuf_cnt_r;
  logic               obuf_last_r;

  // combinational
  logic [LEN_W-1:0]   len_c;
  logic [WIN_W-1:0]   wreq_c;
  logic [WIN_W-1:0]   win_c;
  logic [WIN_W-1:0]   cur_w_c;
  logic               n_ge_w_c;
  logic               n1_ge_w_c;
  logic               fin_c;
  logic [WSQ_W-1:0]   wsq_c;
  logic [WIN_W-1:0]   half_c;
  logic [WIN_W-1:0]   reps_c;
  logic [RF_W-1:0]    rf1_c, rf2_c;
  logic signed [31:0] bdiff_c;
  rar1v_pkg::acc_t    h_sum_c;
  rar1v_pkg::acc_t    g_new_c;
  logic               load_go_c;
  logic               mul_state_c;
  logic               div_state_c;

  // unit interfaces
  logic                    mul_start, mul_done;
  rar1v_pkg::acc_t         mul_a, mul_p;
  logic signed [MB_W-1:0]  mul_b;
  logic                    div_start, div_done;
  logic [ACC_W-1:0]        div_rem0, div_den;
  logic [VAR_W-1:0]        div_dvd, div_q;
  logic [rar1v_pkg::STEP_W-1:0] div_steps;
  logic                    mem_we;
  logic [WIN_W-1:0]        rd_age;
  logic [PTR_W:0]          raddr_w;
  logic [PTR_W-1:0]        raddr;
  rar1v_pkg::sample_t      rdata;

  // --------------------------------------------------------------------------
  // window resolution from the current register values
  // --------------------------------------------------------------------------
  assign len_c = (cfg_len_r == '0) ? LEN_W'(1) : cfg_len_r;

  always_comb begin
    wreq_c = (cfg_win_r != '0) ? cfg_win_r : WIN_W'(rar1v_pkg::DEFAULT_WINDOW);
    if (wreq_c < WIN_W'(rar1v_pkg::MIN_WINDOW)) begin
      wreq_c = WIN_W'(rar1v_pkg::MIN_WINDOW);
    end
    if (LEN_W'(wreq_c) > len_c) begin
      wreq_c = len_c[WIN_W-1:0];
    end
    if (wreq_c > WIN_W'(rar1v_pkg::MAX_WINDOW)) begin
      wreq_c = WIN_W'(rar1v_pkg::MAX_WINDOW);
    end
    if (!wreq_c[0]) begin
      if (LEN_W'(wreq_c) == len_c || wreq_c == WIN_W'(rar1v_pkg::MAX_WINDOW)) begin
        wreq_c = wreq_c - 1'b1;
      end else begin
        wreq_c = wreq_c + 1'b1;
      end
    end
    win_c = (len_c < LEN_W'(rar1v_pkg::MIN_WINDOW)) ? '0 : wreq_c;
  end

  assign cur_w_c   = (n_r == '0) ? win_c : w_r;
  assign n_ge_w_c  = (n_r >= LEN_W'(w_r));
  assign n1_ge_w_c = ({1'b0, n_r} + 1'b1 >= (LEN_W + 1)'(w_r));
  assign fin_c     = ({1'b0, n_r} + 1'b1 == {1'b0, len_r});
  assign wsq_c     = WSQ_W'(w_r) * WSQ_W'(w_r);
  assign half_c    = w_r >> 1;
  assign rf1_c     = RF_W'(rar1v_pkg::REG_FACTOR) * (RF_W'(w_r) + RF_W'(1));
  assign rf2_c     = RF_W'(rar1v_pkg::REG_FACTOR) * (RF_W'(w_r) + RF_W'(2));
  assign bdiff_c   = (32'(s_r) <<< 1) - 32'(x_r) - 32'(l_r);
  assign h_sum_c   = h_r + mul_p;
  assign g_new_c   = mul_p - s2_r;

  // results owed by the current sample
  always_comb begin
    if (w_r == '0) begin
      reps_c = WIN_W'(1);
    end else if (!n1_ge_w_c) begin
      reps_c = '0;
    end else begin
      reps_c = ({1'b0, n_r} + 1'b1 == (LEN_W + 1)'(w_r)) ? half_c + 1'b1 : WIN_W'(1);
      if (fin_c) begin
        reps_c = reps_c + half_c;
      end
    end
  end

  assign load_go_c = (reps_c == '0) || (obuf_cnt_r == '0);

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rar1v_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (cur_w_c == '0) ? rar1v_pkg::ST_LOAD : rar1v_pkg::ST_RD_A;
        end
      end
      rar1v_pkg::ST_RD_A: state_nxt = rar1v_pkg::ST_RD_B;
      rar1v_pkg::ST_RD_B: state_nxt = rar1v_pkg::ST_RD_C;
      rar1v_pkg::ST_RD_C: begin
        if (n_ge_w_c) begin
          state_nxt = rar1v_pkg::ST_M_DD;
        end else if (n_r != '0) begin
          state_nxt = rar1v_pkg::ST_M_PX;
        end else begin
          state_nxt = rar1v_pkg::ST_M_XX;
        end
      end
      rar1v_pkg::ST_M_DD: if (mul_done) state_nxt = rar1v_pkg::ST_M_DL;
      rar1v_pkg::ST_M_DL: if (mul_done) state_nxt = rar1v_pkg::ST_M_PX;
      rar1v_pkg::ST_M_PX: if (mul_done) state_nxt = rar1v_pkg::ST_M_XX;
      rar1v_pkg::ST_M_XX: begin
        if (mul_done) begin
          state_nxt = n1_ge_w_c ? rar1v_pkg::ST_V_SS : rar1v_pkg::ST_LOAD;
        end
      end
      rar1v_pkg::ST_V_SS: if (mul_done) state_nxt = rar1v_pkg::ST_V_G;
      rar1v_pkg::ST_V_G:  if (mul_done) state_nxt = rar1v_pkg::ST_V_H1;
      rar1v_pkg::ST_V_H1: if (mul_done) state_nxt = rar1v_pkg::ST_V_H2;
      rar1v_pkg::ST_V_H2: if (mul_done) state_nxt = rar1v_pkg::ST_V_H3;
      rar1v_pkg::ST_V_H3: if (mul_done) state_nxt = rar1v_pkg::ST_V_H4;
      rar1v_pkg::ST_V_H4: begin
        if (mul_done) begin
          if (h_sum_c[ACC_W-1] || h_sum_c == '0) begin
            state_nxt = rar1v_pkg::ST_V_BB;
          end else begin
            state_nxt = rar1v_pkg::ST_V_NUM;
          end
        end
      end
      rar1v_pkg::ST_V_NUM: if (mul_done) state_nxt = rar1v_pkg::ST_V_D1;
      rar1v_pkg::ST_V_D1:  if (mul_done) state_nxt = rar1v_pkg::ST_V_D2;
      rar1v_pkg::ST_V_D2:  if (mul_done) state_nxt = rar1v_pkg::ST_V_D3;
      rar1v_pkg::ST_V_D3:  if (mul_done) state_nxt = rar1v_pkg::ST_V_CMP;
      rar1v_pkg::ST_V_CMP: begin
        if ($unsigned(num_r) >= $unsigned(den_r)) begin
          state_nxt = rar1v_pkg::ST_V_BB;
        end else begin
          state_nxt = rar1v_pkg::ST_V_DIV;
        end
      end
      rar1v_pkg::ST_V_DIV: if (div_done) state_nxt = rar1v_pkg::ST_V_BB;
      rar1v_pkg::ST_V_BB:  if (mul_done) state_nxt = rar1v_pkg::ST_V_GP;
      rar1v_pkg::ST_V_GP:  if (mul_done) state_nxt = rar1v_pkg::ST_V_SAT;
      rar1v_pkg::ST_V_SAT: begin
        if ($unsigned(xv_r) >= (ACC_W'(wsq_c) << VAR_W)) begin
          state_nxt = rar1v_pkg::ST_LOAD;
        end else begin
          state_nxt = rar1v_pkg::ST_V_DIV2;
        end
      end
      rar1v_pkg::ST_V_DIV2: if (div_done) state_nxt = rar1v_pkg::ST_LOAD;
      rar1v_pkg::ST_LOAD: if (load_go_c) state_nxt = rar1v_pkg::ST_IDLE;
      default: state_nxt = rar1v_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: unit controls and operand selection
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready    = 1'b0;
    mul_state_c = 1'b1;
    div_state_c = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_rem0    = num_r;
    div_den     = den_r;
    div_dvd     = '0;
    div_steps   = rar1v_pkg::STEP_W'(rar1v_pkg::BETA_STEPS);
    mem_we      = 1'b0;
    rd_age      = w_r - WIN_W'(2);
    unique case (state_r)
      rar1v_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        mul_state_c = 1'b0;
      end
      rar1v_pkg::ST_RD_A: begin
        mul_state_c = 1'b0;
        rd_age      = w_r - WIN_W'(1);
      end
      rar1v_pkg::ST_RD_B: mul_state_c = 1'b0;
      rar1v_pkg::ST_RD_C: begin
        mul_state_c = 1'b0;
        mem_we      = 1'b1;
      end
      rar1v_pkg::ST_M_DD: begin
        mul_a = ACC_W'(d_r);
        mul_b = MB_W'(d_r);
      end
      rar1v_pkg::ST_M_DL: begin
        mul_a = ACC_W'(d_r);
        mul_b = MB_W'(l_r);
      end
      rar1v_pkg::ST_M_PX: begin
        mul_a = ACC_W'(prev_r);
        mul_b = MB_W'(x_r);
      end
      rar1v_pkg::ST_M_XX: begin
        mul_a = ACC_W'(x_r);
        mul_b = MB_W'(x_r);
      end
      rar1v_pkg::ST_V_SS: begin
        mul_a = ACC_W'(s_r);
        mul_b = MB_W'(s_r);
      end
      rar1v_pkg::ST_V_G: begin
        mul_a = ACC_W'(q_r);
        mul_b = MB_W'(w_r);
      end
      rar1v_pkg::ST_V_H1: begin
        mul_a = ACC_W'(p_r);
        mul_b = MB_W'(wsq_c);
      end
      rar1v_pkg::ST_V_H2: begin
        mul_a = ACC_W'(s_r);
        mul_b = MB_W'(bdiff_c);
      end
      rar1v_pkg::ST_V_H3: begin
        mul_a = t_r;
        mul_b = MB_W'(w_r);
      end
      rar1v_pkg::ST_V_H4: begin
        mul_a = s2_r;
        mul_b = MB_W'(w_r - WIN_W'(1));
      end
      rar1v_pkg::ST_V_NUM: begin
        mul_a = h_r;
        mul_b = MB_W'(rf1_c);
      end
      rar1v_pkg::ST_V_D1: begin
        mul_a = g_r;
        mul_b = MB_W'(rf2_c);
      end
      rar1v_pkg::ST_V_D2: begin
        mul_a = g_r + (ACC_W'(w_r) << 24);
        mul_b = MB_W'(w_r) + MB_W'(1);
      end
      rar1v_pkg::ST_V_D3: begin
        mul_a = den_r;
        mul_b = MB_W'(w_r);
      end
      rar1v_pkg::ST_V_CMP: mul_state_c = 1'b0;
      rar1v_pkg::ST_V_DIV: begin
        mul_state_c = 1'b0;
        div_state_c = 1'b1;
      end
      rar1v_pkg::ST_V_BB: begin
        mul_a = ACC_W'(beta_r);
        mul_b = MB_W'(beta_r);
      end
      rar1v_pkg::ST_V_GP: begin
        mul_a = g_r;
        mul_b = MB_W'(om_r);
      end
      rar1v_pkg::ST_V_SAT: mul_state_c = 1'b0;
      rar1v_pkg::ST_V_DIV2: begin
        mul_state_c = 1'b0;
        div_state_c = 1'b1;
        // quotient fits VAR_W bits, so preset the remainder with the high part
        div_rem0    = $unsigned(xv_r) >> VAR_W;
        div_den     = ACC_W'(wsq_c);
        div_dvd     = xv_r[VAR_W-1:0];
        div_steps   = rar1v_pkg::STEP_W'(VAR_W);
      end
      rar1v_pkg::ST_LOAD: mul_state_c = 1'b0;
      default: mul_state_c = 1'b0;
    endcase
  end

  assign mul_start = mul_state_c && !issued_r;
  assign div_start = div_state_c && !issued_r;

  // read address of age k: slot wp-1-k, modulo the depth
  always_comb begin
    raddr_w = {1'b0, wp_r} + (PTR_W + 1)'(rar1v_pkg::MAX_WINDOW - 1) - (PTR_W + 1)'(rd_age);
    if (raddr_w >= (PTR_W + 1)'(rar1v_pkg::MAX_WINDOW)) begin
      raddr_w = raddr_w - (PTR_W + 1)'(rar1v_pkg::MAX_WINDOW);
    end
    raddr = raddr_w[PTR_W-1:0];
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rar1v_pkg::ST_IDLE;
      cfg_len_r   <= LEN_W'(1);
      cfg_win_r   <= WIN_W'(rar1v_pkg::DEFAULT_WINDOW);
      len_r       <= '0;
      w_r         <= '0;
      n_r         <= '0;
      wp_r        <= '0;
      issued_r    <= 1'b0;
      s_r         <= '0;
      q_r         <= '0;
      p_r         <= '0;
      obuf_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (rar1v_pkg::reg_idx_t'(cfg_index))
          rar1v_pkg::REG_TRACK_LENGTH: cfg_len_r <= cfg_wdata[LEN_W-1:0];
          rar1v_pkg::REG_REQ_WINDOW:   cfg_win_r <= cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end

      // one start per unit-using state
      if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end

      // track settings latched at the first sample
      if (state_r == rar1v_pkg::ST_IDLE && in_valid && n_r == '0) begin
        len_r <= len_c;
        w_r   <= win_c;
      end

      if (state_r == rar1v_pkg::ST_RD_C) begin
        wp_r <= (wp_r == PTR_W'(rar1v_pkg::MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
      end

      if (mul_done) begin
        unique case (state_r)
          rar1v_pkg::ST_M_DD: q_r <= q_r - mul_p[rar1v_pkg::SUM_Q_W-1:0];
          rar1v_pkg::ST_M_DL: p_r <= p_r - mul_p[rar1v_pkg::SUM_P_W-1:0];
          rar1v_pkg::ST_M_PX: p_r <= p_r + mul_p[rar1v_pkg::SUM_P_W-1:0];
          rar1v_pkg::ST_M_XX: begin
            q_r <= q_r + mul_p[rar1v_pkg::SUM_Q_W-1:0];
            s_r <= s_r + rar1v_pkg::SUM_S_W'(x_r)
                 - (n_ge_w_c ? rar1v_pkg::SUM_S_W'(d_r) : '0);
          end
          default: ;
        endcase
      end

      // output register: load when empty, else drain one beat per handshake
      if (state_r == rar1v_pkg::ST_LOAD && load_go_c && reps_c != '0) begin
        obuf_cnt_r <= reps_c;
      end else if (out_valid && out_ready) begin
        obuf_cnt_r <= obuf_cnt_r - 1'b1;
      end

      if (state_r == rar1v_pkg::ST_LOAD && load_go_c) begin
        if (fin_c) begin
          // track end: per-track state back to its start values
          n_r <= '0;
          w_r <= '0;
          s_r <= '0;
          q_r <= '0;
          p_r <= '0;
        end else begin
          n_r <= n_r + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == rar1v_pkg::ST_IDLE && in_valid) begin
      x_r <= in_sample;
      if (cur_w_c == '0) begin
        var_r <= '0;
      end
    end
    if (state_r == rar1v_pkg::ST_RD_B) begin
      d_r <= rdata;
    end
    if (state_r == rar1v_pkg::ST_RD_C) begin
      l_r <= rdata;
    end

    if (mul_done) begin
      unique case (state_r)
        rar1v_pkg::ST_V_SS:  s2_r  <= mul_p;
        rar1v_pkg::ST_V_G:   g_r   <= g_new_c[ACC_W-1] ? '0 : g_new_c;
        rar1v_pkg::ST_V_H1:  h_r   <= mul_p;
        rar1v_pkg::ST_V_H2:  t_r   <= mul_p;
        rar1v_pkg::ST_V_H3:  h_r   <= h_r - mul_p;
        rar1v_pkg::ST_V_H4: begin
          h_r <= h_sum_c;
          if (h_sum_c[ACC_W-1] || h_sum_c == '0) begin
            beta_r <= '0;
          end
        end
        rar1v_pkg::ST_V_NUM: num_r <= mul_p;
        rar1v_pkg::ST_V_D1:  den_r <= mul_p;
        rar1v_pkg::ST_V_D2:  den_r <= den_r + mul_p;
        rar1v_pkg::ST_V_D3:  den_r <= mul_p;
        rar1v_pkg::ST_V_BB: begin
          om_r <= (rar1v_pkg::BETA_W + 1)'(rar1v_pkg::Q30_ONE)
                - (rar1v_pkg::BETA_W + 1)'(mul_p[2*rar1v_pkg::BETA_W-1:rar1v_pkg::BETA_W]);
        end
        rar1v_pkg::ST_V_GP:  xv_r  <= mul_p >>> rar1v_pkg::BETA_W;
        default: ;
      endcase
    end

    if (state_r == rar1v_pkg::ST_V_CMP && $unsigned(num_r) >= $unsigned(den_r)) begin
      beta_r <= rar1v_pkg::BETA_W'(rar1v_pkg::BETA_CAP);
    end
    if (state_r == rar1v_pkg::ST_V_DIV && div_done) begin
      beta_r <= (div_q > VAR_W'(rar1v_pkg::BETA_CAP)) ?
                rar1v_pkg::BETA_W'(rar1v_pkg::BETA_CAP) : div_q[rar1v_pkg::BETA_W-1:0];
    end
    if (state_r == rar1v_pkg::ST_V_SAT && $unsigned(xv_r) >= (ACC_W'(wsq_c) << VAR_W)) begin
      var_r <= '1;
    end
    if (state_r == rar1v_pkg::ST_V_DIV2 && div_done) begin
      var_r <= div_q;
    end

    if (state_r == rar1v_pkg::ST_LOAD && load_go_c) begin
      prev_r <= x_r;
      if (reps_c != '0) begin
        obuf_var_r  <= var_r;
        obuf_last_r <= fin_c;
      end
    end
  end

  assign out_valid    = (obuf_cnt_r != '0);
  assign out_variance = obuf_var_r;
  assign out_is_last  = obuf_last_r && (obuf_cnt_r == WIN_W'(1));

  // --------------------------------------------------------------------------
  // units
  // --------------------------------------------------------------------------
  rar1v_dline u_dline (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  rar1v_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  rar1v_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .rem0  (div_rem0),
    .den   (div_den),
    .dvd   (div_dvd),
    .steps (div_steps),
    .done  (div_done),
    .q     (div_q)
  );

endmodule

// ----- tb/tb_rolling_ar1_innovation_variance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rolling_ar1_innovation_variance: self-checking bench
// Streams sample tracks through the block under many length and window
// settings. A cycle-free predictor works out each expected variance beat,
// and a monitor checks every output beat against it, field by field.
// ----------------------------------------------------------------------------
module tb_rolling_ar1_innovation_variance;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [rar1v_pkg::VAR_W-1:0] variance;
    logic                        is_last;
  } var_beat_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  rar1v_pkg::sample_t               in_sample = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [rar1v_pkg::VAR_W-1:0]      out_variance;
  logic                             out_is_last;
  logic                             cfg_we = 1'b0;
  logic [rar1v_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rar1v_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  rolling_ar1_innovation_variance u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit, far above the slowest legal run
  initial begin
    #30ms;
    $display("FAIL rolling_ar1_innovation_variance");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's registers and per-track sums
  // ---------------------------------------------------------------------------
  logic [31:0] len_reg;
  logic [5:0]  win_reg;
  longint      trk_len;        // latched at first sample of a track
  int          trk_win;        // 0 means short-track mode
  longint      trk_seen;
  wide_t       hist [rar1v_pkg::MAX_WINDOW];  // index = age, 0 newest
  wide_t       sum_s, sum_q, sum_p;

  var_beat_t   pending_vars[$];
  int          n_errors = 0;
  bit          quiet = 1'b0;   // suppresses random idling on both sides
  int          rand_sent = 0;

  task automatic clear_track();
    for (int i = 0; i < rar1v_pkg::MAX_WINDOW; i++) hist[i] = '0;
    sum_s = '0;
    sum_q = '0;
    sum_p = '0;
    trk_seen = 0;
    trk_win = 0;
  endtask

  function automatic int pick_window(longint len, int req);
    int w;
    if (len < rar1v_pkg::MIN_WINDOW) return 0;
    w = (req != 0) ? req : rar1v_pkg::DEFAULT_WINDOW;
    if (w < rar1v_pkg::MIN_WINDOW) w = rar1v_pkg::MIN_WINDOW;
    if (w > len) w = int'(len);
    if (w > rar1v_pkg::MAX_WINDOW) w = rar1v_pkg::MAX_WINDOW;
    if (w % 2 == 0) w = (w == len || w == rar1v_pkg::MAX_WINDOW) ? w - 1 : w + 1;
    return w;
  endfunction

  // innovation variance of the current full window, Q24.24
  function automatic logic [rar1v_pkg::VAR_W-1:0] ar1_variance(int w);
    wide_t  wv, s, s2, g, h, num, den, prod, wsq;
    longint beta;
    longint one_minus;
    wv = w;
    wsq = wv * wv;
    s = sum_s;
    s2 = s * s;
    g = wv * sum_q - s2;
    if (g < 0) g = '0;
    h = wsq * sum_p - wv * s * (2 * s - hist[0] - hist[w-1]) + (wv - 1) * s2;
    beta = 0;
    if (h > 0) begin
      num = h * rar1v_pkg::REG_FACTOR * (wv + 1);
      den = wv * (g * rar1v_pkg::REG_FACTOR * (wv + 2) + (g + (wv <<< 24)) * (wv + 1));
      if (num >= den) begin
        beta = rar1v_pkg::BETA_CAP;
      end else begin
        for (int i = 0; i < rar1v_pkg::BETA_STEPS; i++) begin
          num = num + num;
          beta = beta << 1;
          if (num >= den) begin
            num = num - den;
            beta = beta | 1;
          end
        end
        if (beta > rar1v_pkg::BETA_CAP) beta = rar1v_pkg::BETA_CAP;
      end
    end
    one_minus = longint'(rar1v_pkg::Q30_ONE) - ((beta * beta) >> 30);
    prod = (g * one_minus) >>> 30;
    if (prod >= (wsq <<< 48)) return {rar1v_pkg::VAR_W{1'b1}};
    return rar1v_pkg::VAR_W'(prod / wsq);
  endfunction

  task automatic predict_sample(rar1v_pkg::sample_t x);
    wide_t     xv, d;
    longint    n;
    int        w, reps;
    logic      fin;
    var_beat_t b;
    if (trk_seen == 0) begin
      trk_len = (len_reg == 0) ? 1 : longint'(len_reg);
      trk_win = pick_window(trk_len, int'(win_reg));
    end
    n = trk_seen;
    w = trk_win;
    fin = (n + 1 == trk_len);
    xv = x;
    if (w == 0) begin
      b.variance = '0;
      b.is_last = fin;
      pending_vars.push_back(b);
    end else begin
      if (n >= w) begin
        d = hist[w-1];
        sum_s -= d;
        sum_q -= d * d;
        sum_p -= d * hist[w-2];
      end
      if (n >= 1) sum_p += hist[0] * xv;
      sum_s += xv;
      sum_q += xv * xv;
      for (int i = rar1v_pkg::MAX_WINDOW - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = xv;
      if (n + 1 >= w) begin
        b.variance = ar1_variance(w);
        reps = (n + 1 == w) ? w / 2 + 1 : 1;
        if (fin) reps += w / 2;
        for (int k = 0; k < reps; k++) begin
          b.is_last = fin && (k == reps - 1);
          pending_vars.push_back(b);
        end
      end
    end
    trk_seen++;
    if (fin) clear_track();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the beat checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 22);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
  endtask

  always @(posedge clk) begin
    var_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vars.size() == 0) begin
        report_mismatch("unexpected beat", out_variance, 0);
      end else begin
        want = pending_vars.pop_front();
        if (out_variance !== want.variance)
          report_mismatch("variance", out_variance, want.variance);
        if (out_is_last !== want.is_last)
          report_mismatch("is_last", out_is_last, want.is_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Leaves in_valid high after acceptance; drop_valid lowers it, and the next call may lower it while idling.
  task automatic send_sample(rar1v_pkg::sample_t x);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_sample <= x;
    predict_sample(x);
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // every expected beat is back, then let a filling sample finish
  task automatic wait_drained(int settle);
    while (pending_vars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(rar1v_pkg::reg_idx_t idx,
                           logic [rar1v_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == rar1v_pkg::REG_TRACK_LENGTH) len_reg = data;
    else win_reg = data[5:0];
    @(posedge clk);
  endtask

  task automatic set_track(logic [31:0] len, logic [5:0] win, bit noise);
    drop_valid();
    wait_drained(800);
    if (noise) write_reg(rar1v_pkg::REG_TRACK_LENGTH, $urandom());
    write_reg(rar1v_pkg::REG_TRACK_LENGTH, len);
    write_reg(rar1v_pkg::REG_REQ_WINDOW, 32'(win));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rar1v_pkg::sample_t clamp_sample(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return rar1v_pkg::sample_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_short_tracks();
    set_track(32'd0, 6'd0, 1'b0);       // zero length acts as one
    send_sample(24'sh7FFFFF);
    set_track(32'd4, 6'd63, 1'b0);      // below the minimum window
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh000000);
    send_sample(-24'sd1);
  endtask

  task automatic test_small_windows();
    // length 5, default request: window shrinks to 5, edges replicated
    set_track(32'd5, 6'd0, 1'b0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    // even window equal to the length drops to 5; constant data, zero spread
    set_track(32'd6, 6'd6, 1'b0);
    repeat (6) send_sample(24'sh123456);
    // request below the minimum raises to 5; a ramp gives a strong lag-1 term
    set_track(32'd7, 6'd1, 1'b0);
    for (int i = 0; i < 7; i++) send_sample(rar1v_pkg::sample_t'(i * 1000 - 3000));
  endtask

  task automatic test_random_tracks();
    int     len, style, pause_at, trk;
    longint v;
    trk = 0;
    while (rand_sent < 310) begin
      case ($urandom_range(19))
        0, 1:    len = int'($urandom_range(4));
        2, 3, 4: len = int'($urandom_range(100, 41));
        default: len = int'($urandom_range(40, 5));
      endcase
      quiet = (trk == 3);           // one long stretch without idling
      set_track(32'(len), 6'($urandom_range(63)), $urandom_range(3) == 0);
      style = int'($urandom_range(3));
      if (trk == 0 || $urandom_range(4) == 0) begin
        pause_at = (len > 1) ? int'($urandom_range(len - 1)) : 0;
      end else begin
        pause_at = -1;
      end
      v = $signed($urandom_range(16'hFFFF)) - 32768;
      for (int i = 0; i < (len == 0 ? 1 : len); i++) begin
        if (i == pause_at) begin
          drop_valid();
          wait_drained(0);          // hold off until the block has caught up
        end
        case (style)
          0: v = $signed(24'($urandom()));
          1: v = v + $signed($urandom_range(4000)) - 2000;   // near unit root
          2: v = $signed($urandom_range(63)) - 32;
          default: v = ($urandom_range(1) != 0) ? 8388607 : -8388608;
        endcase
        send_sample(clamp_sample(v));
        rand_sent++;
      end
      quiet = 1'b0;
      trk++;
    end
    // largest window on a full-size track
    set_track(32'd70, 6'd62, 1'b0);
    for (int i = 0; i < 70; i++) send_sample(rar1v_pkg::sample_t'($urandom()));
  endtask

  initial begin
    len_reg = 32'd1;
    win_reg = 6'(rar1v_pkg::DEFAULT_WINDOW);
    trk_len = 0;
    clear_track();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_tracks();
    test_small_windows();
    test_random_tracks();

    drop_valid();
    wait_drained(1000);
    if (n_errors == 0 && pending_vars.size() == 0) begin
      $display("PASS rolling_ar1_innovation_variance");
    end else begin
      $display("FAIL rolling_ar1_innovation_variance");
    end
    $finish;
  end

endmodule
